/* hw/rtl/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg
// Shared defaults and types for the running sample statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

    // Default sizes: sample width, counter width, fraction bits of the mean
    localparam int DEF_VALUE_BITS    = 7;
    localparam int DEF_COUNT_BITS    = 16;
    localparam int DEF_FRACTION_BITS = 8;

    // Status of the iterative divider as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

/* hw/rtl/rss_ram.sv */
// ----------------------------------------------------------------------------
// rss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read; read data is registered and appears in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/rss_div.sv */
// ----------------------------------------------------------------------------
// rss_div
// Restoring divider, one quotient bit per cycle. The upper COUNT_BITS of the
// dividend must be below the divisor, so the quotient fits QUOT_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_div
    import rss_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int QUOT_BITS  = DEF_VALUE_BITS + DEF_FRACTION_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [COUNT_BITS+QUOT_BITS-1:0] i_num,
    input  wire logic [COUNT_BITS-1:0]           i_den,
    output t_div_status                          o_status,
    output logic      [QUOT_BITS-1:0]            o_quot
);

    localparam int ITER_BITS = $clog2(QUOT_BITS + 1);

    logic                  r_busy;
    logic [ITER_BITS-1:0]  r_iter;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic [QUOT_BITS-1:0]  r_lo;

    logic [COUNT_BITS:0]   w_shift;
    logic [COUNT_BITS:0]   w_diff;
    logic                  w_ge;

    // Trial subtract of the shifted remainder
    always_comb begin
        w_shift = {r_rem, r_lo[QUOT_BITS-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
    end

    // Control: count down the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= ITER_BITS'(QUOT_BITS);
        end else if (r_busy) begin
            r_iter <= r_iter - 1'b1;
            if (r_iter == ITER_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: remainder and dividend bits shift, quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[COUNT_BITS+QUOT_BITS-1:QUOT_BITS];
            r_lo  <= i_num[QUOT_BITS-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[COUNT_BITS-1:0] : w_shift[COUNT_BITS-1:0];
            r_lo  <= {r_lo[QUOT_BITS-2:0], w_ge};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_busy && (r_iter == ITER_BITS'(1));
    assign o_quot        = r_lo;

endmodule

`default_nettype wire

/* hw/rtl/running_sample_statistics_top.sv */
// ----------------------------------------------------------------------------
// running_sample_statistics_top
// Running max, min, mean, mode and sample count over a stream of samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one sample per word.
//   Output channel (o_out_valid / i_out_ready) carries one word of all
//   statistics for every accepted sample, in order.
//   After reset the histogram memory is cleared one bin per cycle, all
//   2^VALUE_BITS bins (128 by default); no sample is taken then.
//   Each sample takes a histogram read-modify-write, then the mean divider
//   runs one quotient bit per cycle over VALUE_BITS + FRACTION_BITS bits
//   (15 by default). A new sample is taken only once the result of the
//   previous one has moved to the output register.
//   The result sits in an output register; the next sample is accepted
//   while it waits. A stalled receiver holds the following result in the
//   sequencer until the output register frees up.
//   Once the count is full, samples are ignored and flagged saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module running_sample_statistics_top
    import rss_pkg::*;
#(
    parameter int VALUE_BITS    = DEF_VALUE_BITS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [VALUE_BITS-1:0]             i_sample,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [VALUE_BITS-1:0]             o_max_seen,
    output logic      [VALUE_BITS-1:0]             o_min_seen,
    output logic      [VALUE_BITS+FRACTION_BITS-1:0] o_mean_fixed,
    output logic      [VALUE_BITS-1:0]             o_mode_value,
    output logic      [COUNT_BITS-1:0]             o_mode_count,
    output logic      [COUNT_BITS-1:0]             o_samples_seen,
    output logic                                   o_saturated
);

    localparam int BINS      = 1 << VALUE_BITS;
    localparam int SUM_BITS  = VALUE_BITS + COUNT_BITS;
    localparam int MEAN_BITS = VALUE_BITS + FRACTION_BITS;
    localparam int NUM_BITS  = COUNT_BITS + MEAN_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_DIVIDE,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [VALUE_BITS-1:0]  r_clr_addr;
    logic [VALUE_BITS-1:0]  r_sample;
    logic                   r_sat;
    logic [VALUE_BITS-1:0]  r_max;
    logic [VALUE_BITS-1:0]  r_min;
    logic [SUM_BITS-1:0]    r_sum;
    logic [COUNT_BITS-1:0]  r_count;
    logic [VALUE_BITS-1:0]  r_best_value;
    logic [COUNT_BITS-1:0]  r_best_count;

    logic [SUM_BITS-1:0]    n_sum;
    logic [COUNT_BITS-1:0]  n_count;
    logic [COUNT_BITS-1:0]  w_bin;
    logic                   w_full;
    logic                   w_load;

    logic                   ram_we;
    logic [VALUE_BITS-1:0]  ram_waddr;
    logic [COUNT_BITS-1:0]  ram_wdata;
    logic [COUNT_BITS-1:0]  ram_rdata;

    logic                   div_start;
    logic [NUM_BITS-1:0]    div_num;
    t_div_status            div_status;
    logic [MEAN_BITS-1:0]   div_quot;

    // Histogram bins
    rss_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_sample),
        .o_rdata (ram_rdata)
    );

    // Mean divider
    rss_div #(
        .COUNT_BITS (COUNT_BITS),
        .QUOT_BITS  (MEAN_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_num),
        .i_den    (n_count),
        .o_status (div_status),
        .o_quot   (div_quot)
    );

    // Next statistics for the sample under update
    always_comb begin
        w_full  = (r_count == {COUNT_BITS{1'b1}});
        w_bin   = ram_rdata + 1'b1;
        n_sum   = w_full ? r_sum : r_sum + SUM_BITS'(r_sample);
        n_count = w_full ? r_count : r_count + 1'b1;
        div_num = NUM_BITS'(n_sum) << FRACTION_BITS;
    end

    // Memory write: clearing pass, else bin write back
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_UPDATE) && !w_full;
            ram_waddr = r_sample;
            ram_wdata = w_bin;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign div_start  = (r_state == S_UPDATE);
    assign w_load     = (r_state == S_DONE) && (!o_out_valid || i_out_ready);

    // Sequencer and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_max        <= '0;
            r_min        <= '1;
            r_sum        <= '0;
            r_count      <= '0;
            r_best_value <= '0;
            r_best_count <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == {VALUE_BITS{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                    if (!w_full) begin
                        if (r_sample > r_max) begin
                            r_max <= r_sample;
                        end
                        if (r_sample < r_min) begin
                            r_min <= r_sample;
                        end
                        if (w_bin > r_best_count) begin
                            r_best_count <= w_bin;
                            r_best_value <= r_sample;
                        end
                    end
                    r_state <= S_DIVIDE;
                end
                S_DIVIDE: begin
                    if (div_status.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Capture the accepted word and its saturation flag
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_sample <= i_sample;
        end
        if (r_state == S_UPDATE) begin
            r_sat <= w_full;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_max_seen     <= r_max;
            o_min_seen     <= r_min;
            o_mean_fixed   <= div_quot;
            o_mode_value   <= r_best_value;
            o_mode_count   <= r_best_count;
            o_samples_seen <= r_count;
            o_saturated    <= r_sat;
        end
    end

`ifndef ASSERT_OFF
    // A new result word comes only from the finished state
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word loaded outside the finished state");

    // Sample count and sum change only in the update cycle
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_UPDATE) |=> $stable(r_count) && $stable(r_sum))
        else $error("statistics changed outside the update cycle");

    // Once any sample is in, min does not exceed max
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("running min above running max");

    // The mode cannot occur more often than samples were taken
    a_mode_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_count <= r_count)
        else $error("mode count above sample count");
`endif

endmodule

`default_nettype wire
